/* rtl/core/hbm_pkg.sv */
`default_nettype none

package hbm_pkg;

    localparam int NUM_MC    = 4;
    localparam int NUM_PEERS = 8;

    localparam int ID_W      = 29;
    localparam int NOW_W     = 32;
    localparam int TMO_W     = 16;
    localparam int IDX_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int MC_OUT_W  = 4;
    localparam int VCU_OUT_W = 8;

    localparam int BMU_POS   = 0;
    localparam int MC_POS    = BMU_POS + 1;
    localparam int PEER_POS  = MC_POS + NUM_MC;
    localparam int DVL_POS   = PEER_POS + NUM_PEERS;
    localparam int NUM_NODES = DVL_POS + 1;
    localparam int POS_W     = $clog2(NUM_NODES);

    localparam logic [ID_W-1:0]  IDX_MASK    = ID_W'(4'hF);
    localparam logic [TMO_W-1:0] TIMEOUT_RST = TMO_W'(100);

    localparam logic REQ_MSG   = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT = 3'd0,
        CFG_MC_ID   = 3'd1,
        CFG_BMU_ID  = 3'd2,
        CFG_VCU_ID  = 3'd3,
        CFG_SW_ID   = 3'd4,
        CFG_DVL_ID  = 3'd5,
        CFG_RES_ID  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic                 req;
        logic [NOW_W-1:0]     now;
        logic                 hb;
        logic [NUM_NODES-1:0] hit;
        logic [NUM_NODES-1:0] alive;
        logic [NUM_NODES-1:0] expd;
    } tok_t;

endpackage

`default_nettype wire

/* rtl/core/hbm_decode.sv */
`default_nettype none

module hbm_decode
    import hbm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ID_W-1:0]      cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 req_type,
    input  wire logic [ID_W-1:0]      msg_id,
    input  wire logic [NOW_W-1:0]     now_ms,
    output logic [TMO_W-1:0]          timeout,
    output logic                      out_valid,
    output tok_t                      out_tok,
    input  wire logic                 out_ready
);

    logic [TMO_W-1:0] timeout_reg;
    logic [ID_W-1:0]  mc_id_reg;
    logic [ID_W-1:0]  bmu_id_reg;
    logic [ID_W-1:0]  vcu_id_reg;
    logic [ID_W-1:0]  sw_id_reg;
    logic [ID_W-1:0]  dvl_id_reg;
    logic [ID_W-1:0]  res_id_reg;
    logic             valid_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic [ID_W-1:0]  base;
    logic [IDX_W-1:0] idx;
    logic             m_mc;
    logic             m_bmu;
    logic             m_vcu;
    logic             m_sw;
    logic             m_dvl;
    logic             m_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            mc_id_reg   <= '0;
            bmu_id_reg  <= '0;
            vcu_id_reg  <= '0;
            sw_id_reg   <= '0;
            dvl_id_reg  <= '0;
            res_id_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_data[TMO_W-1:0];
                CFG_MC_ID:   mc_id_reg   <= cfg_data;
                CFG_BMU_ID:  bmu_id_reg  <= cfg_data;
                CFG_VCU_ID:  vcu_id_reg  <= cfg_data;
                CFG_SW_ID:   sw_id_reg   <= cfg_data;
                CFG_DVL_ID:  dvl_id_reg  <= cfg_data;
                CFG_RES_ID:  res_id_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign base  = msg_id & ~IDX_MASK;
    assign idx   = msg_id[IDX_W-1:0];
    assign m_mc  = (base == mc_id_reg);
    assign m_bmu = (base == bmu_id_reg);
    assign m_vcu = (base == vcu_id_reg);
    assign m_sw  = (base == sw_id_reg);
    assign m_dvl = (base == dvl_id_reg);
    assign m_res = (msg_id == res_id_reg);

    always_comb
    begin
        tok_next       = '0;
        tok_next.req   = req_type;
        tok_next.now   = now_ms;
        if (!req_type)
        begin
            tok_next.hb = m_mc | m_bmu | m_vcu | m_sw | m_dvl | m_res;
            if (m_mc)
            begin
                for (int i = 0; i < NUM_MC; i++)
                begin
                    tok_next.hit[MC_POS + i] = (idx == IDX_W'(i));
                end
            end
            else if (m_bmu)
            begin
                tok_next.hit[BMU_POS] = 1'b1;
            end
            else if (m_vcu)
            begin
                for (int i = 0; i < NUM_PEERS; i++)
                begin
                    tok_next.hit[PEER_POS + i] = (idx == IDX_W'(i));
                end
            end
            else if (!m_sw && m_dvl)
            begin
                tok_next.hit[DVL_POS] = 1'b1;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tok_reg <= tok_next;
        end
    end

    assign timeout   = timeout_reg;
    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

`default_nettype wire

/* rtl/core/hbm_cell.sv */
`default_nettype none

module hbm_cell
    import hbm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [POS_W-1:0] pos,
    input  wire logic [TMO_W-1:0] timeout,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire tok_t             in_tok,
    output logic                  out_valid,
    output tok_t                  out_tok,
    input  wire logic             out_ready
);

    logic [NOW_W-1:0] seen_reg;
    logic [NOW_W-1:0] seen_next;
    logic             alive_reg;
    logic             alive_next;
    logic             valid_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic [NOW_W-1:0] elapsed;
    logic             expired;
    logic             load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign elapsed  = in_tok.now - seen_reg;
    assign expired  = elapsed > NOW_W'(timeout);

    always_comb
    begin
        seen_next  = seen_reg;
        alive_next = alive_reg;
        if (!in_tok.req && in_tok.hit[pos])
        begin
            seen_next  = in_tok.now;
            alive_next = 1'b1;
        end
        else if (in_tok.req && expired)
        begin
            alive_next = 1'b0;
        end
        tok_next            = in_tok;
        tok_next.alive[pos] = alive_next;
        tok_next.expd[pos]  = in_tok.req && expired;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            alive_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                seen_reg  <= seen_next;
                alive_reg <= alive_next;
            end
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg <= tok_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

`default_nettype wire

/* rtl/core/hbm_result.sv */
`default_nettype none

module hbm_result
    import hbm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire tok_t                  in_tok,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       is_heartbeat,
    output logic                       check_ok,
    output logic                       bmu_alive,
    output logic [MC_OUT_W-1:0]        mciso_alive,
    output logic [VCU_OUT_W-1:0]       vcu_alive,
    output logic                       dvl_alive,
    output logic                       bmu_fault,
    output logic                       mciso_fault
);

    logic                 valid_reg;
    logic                 hb_reg;
    logic                 ok_reg;
    logic [NUM_NODES-1:0] alive_reg;
    logic                 bmu_fault_reg;
    logic                 bmu_fault_next;
    logic                 mc_fault_reg;
    logic                 mc_fault_next;
    logic                 load;
    logic                 mc_lost;
    logic                 ok_next;

    assign in_ready = !valid_reg || !out_stall;
    assign load     = in_valid && in_ready;
    assign mc_lost  = |in_tok.expd[MC_POS +: NUM_MC];
    assign ok_next  = in_tok.req && !in_tok.expd[BMU_POS] && !mc_lost;

    always_comb
    begin
        bmu_fault_next = bmu_fault_reg;
        mc_fault_next  = mc_fault_reg;
        if (in_tok.req)
        begin
            bmu_fault_next = bmu_fault_reg | in_tok.expd[BMU_POS];
            mc_fault_next  = mc_fault_reg | mc_lost;
        end
        else
        begin
            if (in_tok.hit[BMU_POS])
            begin
                bmu_fault_next = 1'b0;
            end
            if (&in_tok.alive[MC_POS +: NUM_MC])
            begin
                mc_fault_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            bmu_fault_reg <= 1'b0;
            mc_fault_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (load)
            begin
                bmu_fault_reg <= bmu_fault_next;
                mc_fault_reg  <= mc_fault_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hb_reg    <= in_tok.hb;
            ok_reg    <= ok_next;
            alive_reg <= in_tok.alive;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MC_OUT_W; g++)
        begin : g_mc
            if (g < NUM_MC)
            begin : g_on
                assign mciso_alive[g] = alive_reg[MC_POS + g];
            end
            else
            begin : g_off
                assign mciso_alive[g] = 1'b0;
            end
        end
        for (g = 0; g < VCU_OUT_W; g++)
        begin : g_vcu
            if (g < NUM_PEERS)
            begin : g_on
                assign vcu_alive[g] = alive_reg[PEER_POS + g];
            end
            else
            begin : g_off
                assign vcu_alive[g] = 1'b0;
            end
        end
    endgenerate

    assign out_valid    = valid_reg;
    assign is_heartbeat = hb_reg;
    assign check_ok     = ok_reg;
    assign bmu_alive    = alive_reg[BMU_POS];
    assign dvl_alive    = alive_reg[DVL_POS];
    assign bmu_fault    = bmu_fault_reg;
    assign mciso_fault  = mc_fault_reg;

endmodule

`default_nettype wire

/* rtl/core/can_node_heartbeat_monitor.sv */
// Channel   Handshake              Payload
// input     in_valid / in_stall    req_type, msg_id, now_ms
// output    out_valid / out_stall  is_heartbeat, check_ok, alive maps, fault flags
// config    cfg_we                 cfg_index, cfg_data
//
// One item enters per cycle while in_stall is low; each item passes in order through
// the decode stage, one cell per watched node and the result register.
// Each cell holds one node's last-seen time and alive bit and does one 32-bit
// elapsed-time compare as the item passes through it.
// Reset clears all times, alive bits and fault flags and loads the reset configuration.
// A stalled output holds back only the stages behind it; empty stages keep filling.
`default_nettype none

module can_node_heartbeat_monitor
    import hbm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ID_W-1:0]      cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 req_type,
    input  wire logic [ID_W-1:0]      msg_id,
    input  wire logic [NOW_W-1:0]     now_ms,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      is_heartbeat,
    output logic                      check_ok,
    output logic                      bmu_alive,
    output logic [MC_OUT_W-1:0]       mciso_alive,
    output logic [VCU_OUT_W-1:0]      vcu_alive,
    output logic                      dvl_alive,
    output logic                      bmu_fault,
    output logic                      mciso_fault
);

    logic             in_ready;
    logic [TMO_W-1:0] timeout;
    logic             chain_valid [NUM_NODES+1];
    logic             chain_ready [NUM_NODES+1];
    tok_t             chain_tok   [NUM_NODES+1];

    hbm_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .msg_id    (msg_id),
        .now_ms    (now_ms),
        .timeout   (timeout),
        .out_valid (chain_valid[0]),
        .out_tok   (chain_tok[0]),
        .out_ready (chain_ready[0])
    );

    genvar j;
    generate
        for (j = 0; j < NUM_NODES; j++)
        begin : g_cell
            hbm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .pos       (POS_W'(j)),
                .timeout   (timeout),
                .in_valid  (chain_valid[j]),
                .in_ready  (chain_ready[j]),
                .in_tok    (chain_tok[j]),
                .out_valid (chain_valid[j+1]),
                .out_tok   (chain_tok[j+1]),
                .out_ready (chain_ready[j+1])
            );
        end
    endgenerate

    hbm_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (chain_valid[NUM_NODES]),
        .in_ready     (chain_ready[NUM_NODES]),
        .in_tok       (chain_tok[NUM_NODES]),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_heartbeat (is_heartbeat),
        .check_ok     (check_ok),
        .bmu_alive    (bmu_alive),
        .mciso_alive  (mciso_alive),
        .vcu_alive    (vcu_alive),
        .dvl_alive    (dvl_alive),
        .bmu_fault    (bmu_fault),
        .mciso_fault  (mciso_fault)
    );

    assign in_stall = !in_ready;

endmodule

`default_nettype wire

/* rtl/core/hbm_checker.sv */
`default_nettype none

module hbm_props
    import hbm_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic                 is_heartbeat,
    input wire logic                 check_ok,
    input wire logic                 bmu_alive,
    input wire logic [MC_OUT_W-1:0]  mciso_alive,
    input wire logic [VCU_OUT_W-1:0] vcu_alive,
    input wire logic                 dvl_alive,
    input wire logic                 bmu_fault,
    input wire logic                 mciso_fault
);

    localparam logic [MC_OUT_W-1:0] MC_FULL = MC_OUT_W'((1 << NUM_MC) - 1);

    // A result that waits keeps its heartbeat, check and alive fields.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(is_heartbeat) && $stable(check_ok)
            && $stable(mciso_alive) && $stable(vcu_alive) && $stable(bmu_alive)
            && $stable(dvl_alive))
        else $error("result changed while stalled");

    // A message never passes a check, and a check never reports a heartbeat.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_heartbeat && check_ok))
        else $error("heartbeat and check flags both set");

    // After a message, the motor controller fault survives only while one is missing.
    a_mc_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_heartbeat && mciso_fault && (NUM_MC <= MC_OUT_W)
            |-> mciso_alive != MC_FULL)
        else $error("motor controller fault kept with all controllers alive");

    // A passed check leaves no new battery fault behind it.
    a_bmu_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && check_ok && !out_stall ##1 out_valid && check_ok
            |-> bmu_fault == $past(bmu_fault))
        else $error("battery fault changed across passing checks");

endmodule

bind can_node_heartbeat_monitor hbm_props u_hbm_props (.*);

`default_nettype wire

/* test/hbm_checker.sv */
module hbm_checker
    import hbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ID_W-1:0]      cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 req_type,
    input  logic [ID_W-1:0]      msg_id,
    input  logic [NOW_W-1:0]     now_ms,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 is_heartbeat,
    input  logic                 check_ok,
    input  logic                 bmu_alive,
    input  logic [MC_OUT_W-1:0]  mciso_alive,
    input  logic [VCU_OUT_W-1:0] vcu_alive,
    input  logic                 dvl_alive,
    input  logic                 bmu_fault,
    input  logic                 mciso_fault,
    output int                   mismatch_count,
    output int                   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                 hb;
        logic                 ok;
        logic                 bmu;
        logic [MC_OUT_W-1:0]  mc;
        logic [VCU_OUT_W-1:0] vcu;
        logic                 dvl;
        logic                 bmu_flt;
        logic                 mc_flt;
    } node_status_t;

    logic [TMO_W-1:0]     timeout_cfg;
    logic [ID_W-1:0]      mc_base;
    logic [ID_W-1:0]      bmu_base;
    logic [ID_W-1:0]      vcu_base;
    logic [ID_W-1:0]      sw_base;
    logic [ID_W-1:0]      dvl_base;
    logic [ID_W-1:0]      res_exact;

    logic [NOW_W-1:0]     bmu_seen;
    logic [NOW_W-1:0]     mc_seen [NUM_MC];
    logic [NOW_W-1:0]     peer_seen [NUM_PEERS];
    logic [NOW_W-1:0]     dvl_seen;
    logic [NUM_NODES-1:0] alive;
    logic [1:0]           fault;

    node_status_t         expected_status [$];
    int                   results_seen;

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
        results_seen   = 0;
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("ERROR: %s", what);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
        begin
            flag_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                    results_seen, name, got, want));
        end
    endtask

    function automatic logic lapsed(input logic [NOW_W-1:0] t, input logic [NOW_W-1:0] seen);
        logic [NOW_W-1:0] elapsed;
        elapsed = t - seen;
        return elapsed > NOW_W'(timeout_cfg);
    endfunction

    function automatic node_status_t advance_heartbeats(input logic rq,
                                                        input logic [ID_W-1:0] id,
                                                        input logic [NOW_W-1:0] t);
        node_status_t     s;
        logic [IDX_W-1:0] node;
        logic [ID_W-1:0]  base;
        s    = '0;
        node = id[IDX_W-1:0];
        base = id & ~IDX_MASK;
        if (rq == REQ_MSG)
        begin
            if (base == mc_base)
            begin
                s.hb = 1'b1;
                if (int'(node) < NUM_MC)
                begin
                    mc_seen[node]        = t;
                    alive[MC_POS + node] = 1'b1;
                end
            end
            else if (base == bmu_base)
            begin
                s.hb           = 1'b1;
                bmu_seen       = t;
                alive[BMU_POS] = 1'b1;
                fault[0]       = 1'b0;
            end
            else if (base == vcu_base)
            begin
                s.hb = 1'b1;
                if (int'(node) < NUM_PEERS)
                begin
                    peer_seen[node]        = t;
                    alive[PEER_POS + node] = 1'b1;
                end
            end
            else if (base == sw_base)
            begin
                s.hb = 1'b1;
            end
            else if (base == dvl_base)
            begin
                s.hb           = 1'b1;
                dvl_seen       = t;
                alive[DVL_POS] = 1'b1;
            end
            else if (id == res_exact)
            begin
                s.hb = 1'b1;
            end
            if (&alive[MC_POS +: NUM_MC])
            begin
                fault[1] = 1'b0;
            end
        end
        else
        begin
            s.ok = 1'b1;
            if (lapsed(t, bmu_seen))
            begin
                alive[BMU_POS] = 1'b0;
                fault[0]       = 1'b1;
                s.ok           = 1'b0;
            end
            for (int i = 0; i < NUM_MC; i++)
            begin
                if (lapsed(t, mc_seen[i]))
                begin
                    alive[MC_POS + i] = 1'b0;
                    fault[1]          = 1'b1;
                    s.ok              = 1'b0;
                end
            end
            for (int i = 0; i < NUM_PEERS; i++)
            begin
                if (lapsed(t, peer_seen[i]))
                begin
                    alive[PEER_POS + i] = 1'b0;
                end
            end
            if (lapsed(t, dvl_seen))
            begin
                alive[DVL_POS] = 1'b0;
            end
        end
        s.bmu     = alive[BMU_POS];
        s.mc      = alive[MC_POS +: NUM_MC];
        s.vcu     = alive[PEER_POS +: NUM_PEERS];
        s.dvl     = alive[DVL_POS];
        s.bmu_flt = fault[0];
        s.mc_flt  = fault[1];
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        node_status_t got;
        node_status_t want;
        if (!rst_n)
        begin
            timeout_cfg = TIMEOUT_RST;
            mc_base     = '0;
            bmu_base    = '0;
            vcu_base    = '0;
            sw_base     = '0;
            dvl_base    = '0;
            res_exact   = '0;
            bmu_seen    = '0;
            dvl_seen    = '0;
            for (int i = 0; i < NUM_MC; i++)
            begin
                mc_seen[i] = '0;
            end
            for (int i = 0; i < NUM_PEERS; i++)
            begin
                peer_seen[i] = '0;
            end
            alive = '0;
            fault = '0;
            expected_status.delete();
            pending_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_TIMEOUT: timeout_cfg = cfg_data[TMO_W-1:0];
                    CFG_MC_ID:   mc_base     = cfg_data;
                    CFG_BMU_ID:  bmu_base    = cfg_data;
                    CFG_VCU_ID:  vcu_base    = cfg_data;
                    CFG_SW_ID:   sw_base     = cfg_data;
                    CFG_DVL_ID:  dvl_base    = cfg_data;
                    CFG_RES_ID:  res_exact   = cfg_data;
                    default:     ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_status.size() == 0)
                begin
                    flag_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                            results_seen));
                end
                else
                begin
                    want = expected_status.pop_front();
                    got  = {is_heartbeat, check_ok, bmu_alive, mciso_alive, vcu_alive,
                            dvl_alive, bmu_fault, mciso_fault};
                    compare_field("is_heartbeat", 32'(got.hb), 32'(want.hb));
                    compare_field("check_ok", 32'(got.ok), 32'(want.ok));
                    compare_field("bmu_alive", 32'(got.bmu), 32'(want.bmu));
                    compare_field("mciso_alive", 32'(got.mc), 32'(want.mc));
                    compare_field("vcu_alive", 32'(got.vcu), 32'(want.vcu));
                    compare_field("dvl_alive", 32'(got.dvl), 32'(want.dvl));
                    compare_field("bmu_fault", 32'(got.bmu_flt), 32'(want.bmu_flt));
                    compare_field("mciso_fault", 32'(got.mc_flt), 32'(want.mc_flt));
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_status.push_back(advance_heartbeats(req_type, msg_id, now_ms));
            end
            pending_count = expected_status.size();
        end
    end

endmodule

/* test/can_node_heartbeat_monitor_tb.sv */
module can_node_heartbeat_monitor_tb;
    import hbm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int   CYCLE_LIMIT = 400000;
    localparam int   ITEMS_PER_PHASE = 150;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ID_W-1:0]      cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 req_type;
    logic [ID_W-1:0]      msg_id;
    logic [NOW_W-1:0]     now_ms;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 is_heartbeat;
    logic                 check_ok;
    logic                 bmu_alive;
    logic [MC_OUT_W-1:0]  mciso_alive;
    logic [VCU_OUT_W-1:0] vcu_alive;
    logic                 dvl_alive;
    logic                 bmu_fault;
    logic                 mciso_fault;

    int                   mismatch_count;
    int                   pending_count;
    int                   cycle_count = 0;
    int                   items_sent = 0;
    int                   in_idle_pct = 0;
    int                   out_idle_pct = 0;

    int                   tmo_set;
    logic [ID_W-1:0]      mc_id;
    logic [ID_W-1:0]      bmu_id;
    logic [ID_W-1:0]      vcu_id;
    logic [ID_W-1:0]      sw_id;
    logic [ID_W-1:0]      dvl_id;
    logic [ID_W-1:0]      res_tag;
    logic [NOW_W-1:0]     wall_ms;

    can_node_heartbeat_monitor u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .msg_id       (msg_id),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_heartbeat (is_heartbeat),
        .check_ok     (check_ok),
        .bmu_alive    (bmu_alive),
        .mciso_alive  (mciso_alive),
        .vcu_alive    (vcu_alive),
        .dvl_alive    (dvl_alive),
        .bmu_fault    (bmu_fault),
        .mciso_fault  (mciso_fault)
    );

    hbm_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .msg_id         (msg_id),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .is_heartbeat   (is_heartbeat),
        .check_ok       (check_ok),
        .bmu_alive      (bmu_alive),
        .mciso_alive    (mciso_alive),
        .vcu_alive      (vcu_alive),
        .dvl_alive      (dvl_alive),
        .bmu_fault      (bmu_fault),
        .mciso_fault    (mciso_fault),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic rq, input logic [ID_W-1:0] id,
                             input logic [NOW_W-1:0] t);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        msg_id   <= id;
        now_ms   <= t;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending_count != 0);
        repeat (NUM_NODES + 4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [ID_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    task automatic program_monitor(input int tmo, input logic [ID_W-1:0] mc,
                                   input logic [ID_W-1:0] bmu, input logic [ID_W-1:0] vcu,
                                   input logic [ID_W-1:0] sw, input logic [ID_W-1:0] dvl,
                                   input logic [ID_W-1:0] res);
        wait_drained();
        tmo_set = tmo;
        mc_id   = mc;
        bmu_id  = bmu;
        vcu_id  = vcu;
        sw_id   = sw;
        dvl_id  = dvl;
        res_tag = res;
        write_reg(CFG_TIMEOUT, ID_W'(tmo));
        write_reg(CFG_MC_ID, mc);
        write_reg(CFG_BMU_ID, bmu);
        write_reg(CFG_VCU_ID, vcu);
        write_reg(CFG_SW_ID, sw);
        write_reg(CFG_DVL_ID, dvl);
        write_reg(CFG_RES_ID, res);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [ID_W-1:0] random_base();
        return ID_W'($urandom) & ~IDX_MASK;
    endfunction

    function automatic logic [ID_W-1:0] some_base();
        case ($urandom_range(0, 4))
            0:       return mc_id;
            1:       return bmu_id;
            2:       return vcu_id;
            3:       return sw_id;
            default: return dvl_id;
        endcase
    endfunction

    task automatic send_msg(input logic [ID_W-1:0] id);
        wall_ms += NOW_W'($urandom_range(0, tmo_set / 8 + 1));
        send_item(REQ_MSG, id, wall_ms);
    endtask

    // Heartbeats from a random subset of nodes, then a timeout check.
    task automatic heartbeat_round();
        int start;
        int k;
        start = $urandom_range(0, NUM_MC - 1);
        if ($urandom_range(0, 9) != 0)
        begin
            send_msg(bmu_id);
        end
        for (k = 0; k < NUM_MC; k++)
        begin
            if ($urandom_range(0, 9) != 0)
            begin
                send_msg(mc_id | ID_W'((start + k) % NUM_MC));
            end
        end
        for (k = 0; k < NUM_PEERS; k++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                send_msg(vcu_id | ID_W'(k));
            end
        end
        if ($urandom_range(0, 2) == 0)
        begin
            send_msg(dvl_id | ID_W'($urandom_range(0, 15)));
        end
        if ($urandom_range(0, 4) == 0)
        begin
            send_msg(sw_id | ID_W'($urandom_range(0, 15)));
        end
        wall_ms += NOW_W'($urandom_range(0, tmo_set / 4 + 1));
        send_item(REQ_CHECK, ID_W'($urandom), wall_ms);
    endtask

    task automatic stray_item();
        case ($urandom_range(0, 5))
            0: send_msg(ID_W'($urandom));
            1: send_msg(some_base() | ID_W'($urandom_range(0, 15)));
            2: send_msg(res_tag);
            3:
            begin
                wall_ms = $urandom;
                send_item(REQ_CHECK, ID_W'($urandom), wall_ms);
            end
            4:
            begin
                wall_ms = $urandom;
                send_item(REQ_MSG, some_base() | ID_W'($urandom_range(0, 15)), wall_ms);
            end
            default:
            begin
                wall_ms += NOW_W'($urandom_range(0, 3 * tmo_set + 3));
                send_item(REQ_CHECK, ID_W'($urandom), wall_ms);
            end
        endcase
    endtask

    initial
    begin
        int               ph;
        int               pick;
        int               phase_end;
        int               tmo;
        logic [ID_W-1:0]  mc;
        logic [ID_W-1:0]  bmu;
        logic [ID_W-1:0]  vcu;
        logic [ID_W-1:0]  sw;
        logic [ID_W-1:0]  dvl;
        logic [ID_W-1:0]  res;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        req_type  = REQ_MSG;
        msg_id    = '0;
        now_ms    = '0;
        tmo_set   = 100;
        mc_id     = '0;
        bmu_id    = '0;
        vcu_id    = '0;
        sw_id     = '0;
        dvl_id    = '0;
        res_tag   = '0;
        wall_ms   = '0;
        in_idle_pct  = 22;
        out_idle_pct = 68;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: every base id is zero, so the motor controllers win.
        send_item(REQ_CHECK, '0, 32'h0000_0000);
        send_item(REQ_CHECK, '1, 32'hFFFF_FFFF);
        send_item(REQ_MSG, 29'h0000_0000, 32'd1000);
        send_item(REQ_MSG, 29'h0000_0001, 32'd1000);
        send_item(REQ_MSG, 29'h0000_0002, 32'd1000);
        send_item(REQ_MSG, 29'h0000_0003, 32'd1000);
        send_item(REQ_MSG, 29'h0000_000F, 32'd1000);
        send_item(REQ_MSG, 29'h1FFF_FFFF, 32'd1000);
        send_item(REQ_CHECK, '0, 32'd1100);
        send_item(REQ_CHECK, '0, 32'd1101);

        program_monitor(100, 29'h0000_0100, 29'h0000_0200, 29'h0000_0300, 29'h0000_0400,
                        29'h0000_0500, 29'h0012_3456);
        send_item(REQ_MSG, 29'h0000_0200, 32'hFFFF_FFF0);
        send_item(REQ_MSG, 29'h0000_0300, 32'hFFFF_FFF0);
        send_item(REQ_MSG, 29'h0000_0307, 32'hFFFF_FFF0);
        send_item(REQ_MSG, 29'h0000_0308, 32'hFFFF_FFF0);
        send_item(REQ_MSG, 29'h0000_030F, 32'hFFFF_FFF0);
        send_item(REQ_MSG, 29'h0000_0403, 32'hFFFF_FFF0);
        send_item(REQ_MSG, 29'h0000_0509, 32'hFFFF_FFF4);
        send_item(REQ_MSG, 29'h0012_3456, 32'hFFFF_FFF4);
        send_item(REQ_MSG, 29'h0012_3457, 32'hFFFF_FFF4);
        send_item(REQ_MSG, 29'h0000_0100, 32'hFFFF_FFF8);
        send_item(REQ_MSG, 29'h0000_0101, 32'hFFFF_FFF8);
        send_item(REQ_MSG, 29'h0000_0102, 32'hFFFF_FFF8);
        send_item(REQ_MSG, 29'h0000_0103, 32'hFFFF_FFF8);
        send_item(REQ_CHECK, '0, 32'h0000_0050);
        send_item(REQ_CHECK, '0, 32'h0000_0064);

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       tmo = 65535;
                1:       tmo = 1;
                2:       tmo = 100;
                3:       tmo = 0;
                4:       tmo = $urandom_range(2, 5000);
                default: tmo = $urandom_range(1, 65535);
            endcase
            mc  = random_base();
            bmu = random_base();
            vcu = random_base();
            sw  = random_base();
            dvl = random_base();
            res = ID_W'($urandom);
            case (ph)
                0:
                begin
                    mc  = '0;
                    bmu = 29'h1FFF_FFF0;
                    res = 29'h1FFF_FFFF;
                end
                2: vcu = bmu;
                3: mc = mc | 29'h5;
                4:
                begin
                    sw  = dvl;
                    res = vcu | 29'h2;
                end
                default: ;
            endcase
            program_monitor(tmo, mc, bmu, vcu, sw, dvl, res);
            if (ph < 2)
            begin
                in_idle_pct  = 22;
                out_idle_pct = 68;
            end
            else if (ph < 4)
            begin
                in_idle_pct  = 68;
                out_idle_pct = 22;
            end
            else
            begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    heartbeat_round();
                end
                else if (pick < 75)
                begin
                    wall_ms += NOW_W'($urandom_range(0, tmo_set + tmo_set / 2 + 2));
                    send_item(REQ_CHECK, ID_W'($urandom), wall_ms);
                end
                else
                begin
                    stray_item();
                end
            end
        end

        wait_drained();
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
